>>> src/smbus_master_status_sequencer_unit_assert.svh
// ---------------------------------------------------------------------------
// SMBus master sequencer assertion macros
// Implication checks, same-cycle and next-cycle, on a clock with an
// active-low reset.
// ---------------------------------------------------------------------------
`ifndef SMBUS_MASTER_STATUS_SEQUENCER_UNIT_ASSERT_SVH
`define SMBUS_MASTER_STATUS_SEQUENCER_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SMSSEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smsseq assertion failed");

// consequent in the cycle after the antecedent
`define SMSSEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smsseq assertion failed");

`endif

>>> src/smsseq_pkg.sv
// ---------------------------------------------------------------------------
// smsseq_pkg
// Types, codes and constants shared by the SMBus master sequencer.
// ---------------------------------------------------------------------------
package smsseq_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int SLOT_W       = 4;
    localparam int CNT_W        = 5;
    localparam int FUNC_W       = 3;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [7:0]       ADDR_MASK = 8'hFE;

    // func codes
    localparam logic [FUNC_W-1:0] FN_LOAD    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_START   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_STATUS  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TIMEOUT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

    // bus engine status codes
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_DIR   = 2'd3;

    typedef struct packed {
        logic [7:0]       slave_address;
        logic [CNT_W-1:0] write_length;
        logic [CNT_W-1:0] read_length;
        logic             read_direction;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        byte_value;
        logic [7:0]        status_code;
    } item_t;

    typedef struct packed {
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       start_request;
        logic       stop_request;
        logic       ack_update;
        logic       ack_level;
        logic       engine_reset;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       rejected;
    } result_t;

endpackage

>>> src/smsseq_store.sv
// ---------------------------------------------------------------------------
// smsseq_store
// Byte register file, one write port and one asynchronous read port.
// ---------------------------------------------------------------------------
module smsseq_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [smsseq_pkg::SLOT_W-1:0] wr_idx,
    input  logic [7:0]                  wr_data,
    input  logic [smsseq_pkg::SLOT_W-1:0] rd_idx,
    output logic [7:0]                  rd_data
);
    import smsseq_pkg::*;

    logic [7:0] mem_reg [BUFFER_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_idx];

endmodule

>>> src/smsseq_core.sv
// ---------------------------------------------------------------------------
// smsseq_core
// Status decode, transfer counters, busy flag and the two byte stores.
// ---------------------------------------------------------------------------
module smsseq_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  smsseq_pkg::item_t   item,
    input  smsseq_pkg::cfg_t    cfg,
    output smsseq_pkg::result_t res
);
    import smsseq_pkg::*;

    logic [CNT_W-1:0] sent_reg, sent_next;
    logic [CNT_W-1:0] recv_reg, recv_next;
    logic             busy_reg, busy_next;

    logic [CNT_W-1:0] sent_m1, recv_m1;
    logic             sent_ok, recv_ok, slot_ok;
    logic [7:0]       wst_rd, rst_rd, tx_data;
    logic             wst_we, rst_we;
    logic [CNT_W-1:0] sent_bump, recv_bump;

    assign sent_m1   = sent_reg - 5'd1;
    assign recv_m1   = recv_reg - 5'd1;
    assign sent_ok   = (sent_reg != '0) && (sent_m1 < CNT_W'(BUFFER_DEPTH));
    assign recv_ok   = (recv_reg != '0) && (recv_m1 < CNT_W'(BUFFER_DEPTH));
    assign slot_ok   = {1'b0, item.slot} < CNT_W'(BUFFER_DEPTH);
    assign tx_data   = sent_ok ? wst_rd : 8'h00;
    assign sent_bump = (sent_reg != COUNT_MAX) ? sent_reg + 5'd1 : sent_reg;
    assign recv_bump = (recv_reg != COUNT_MAX) ? recv_reg + 5'd1 : recv_reg;

    smsseq_store u_wr_store (
        .aclk    (aclk),
        .wr_en   (wst_we),
        .wr_idx  (item.slot),
        .wr_data (item.byte_value),
        .rd_idx  (sent_m1[SLOT_W-1:0]),
        .rd_data (wst_rd)
    );

    smsseq_store u_rd_store (
        .aclk    (aclk),
        .wr_en   (rst_we),
        .wr_idx  (recv_m1[SLOT_W-1:0]),
        .wr_data (item.byte_value),
        .rd_idx  (item.slot),
        .rd_data (rst_rd)
    );

    always_comb begin
        logic lost;
        lost      = 1'b0;
        res       = '0;
        sent_next = sent_reg;
        recv_next = recv_reg;
        busy_next = busy_reg;
        wst_we    = 1'b0;
        rst_we    = 1'b0;
        case (item.func)
            FN_LOAD: begin
                wst_we = fire && slot_ok;
            end
            FN_START: begin
                if (busy_reg) begin
                    res.rejected = 1'b1;
                end else begin
                    busy_next         = 1'b1;
                    res.start_request = 1'b1;
                end
            end
            FN_STATUS: begin
                case (item.status_code)
                    ST_START, ST_RESTART: begin
                        res.tx_load = 1'b1;
                        res.tx_byte = (cfg.slave_address & ADDR_MASK)
                                    | {7'd0, cfg.read_direction};
                        sent_next   = 5'd1;
                        recv_next   = 5'd1;
                    end
                    ST_ADDR_W_ACK: begin
                        res.tx_load = 1'b1;
                        res.tx_byte = tx_data;
                        sent_next   = sent_bump;
                    end
                    ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
                        res.start_request = 1'b1;
                    end
                    ST_DATA_W_ACK: begin
                        if (sent_reg <= cfg.write_length) begin
                            res.tx_load = 1'b1;
                            res.tx_byte = tx_data;
                            sent_next   = sent_bump;
                        end else begin
                            res.stop_request = 1'b1;
                            busy_next        = 1'b0;
                        end
                    end
                    ST_ADDR_R_ACK: begin
                        res.ack_update = 1'b1;
                        res.ack_level  = (recv_reg != cfg.read_length);
                    end
                    ST_DATA_R_ACK: begin
                        res.ack_update = 1'b1;
                        if (recv_reg < cfg.read_length) begin
                            rst_we        = fire && recv_ok;
                            res.ack_level = 1'b1;
                            recv_next     = recv_bump;
                        end
                    end
                    ST_DATA_R_NACK: begin
                        rst_we           = fire && recv_ok;
                        res.stop_request = 1'b1;
                        busy_next        = 1'b0;
                        res.ack_update   = 1'b1;
                        res.ack_level    = 1'b1;
                    end
                    default: begin
                        // arbitration lost or unknown code
                        lost = 1'b1;
                    end
                endcase
                if (lost) begin
                    res.engine_reset = 1'b1;
                    res.ack_update   = 1'b1;
                    busy_next        = 1'b0;
                end
            end
            FN_TIMEOUT: begin
                res.engine_reset = 1'b1;
                busy_next        = 1'b0;
            end
            FN_READ: begin
                res.read_byte = slot_ok ? rst_rd : 8'h00;
            end
            default: begin
            end
        endcase
        res.busy_res = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg <= 5'd1;
            recv_reg <= 5'd1;
            busy_reg <= 1'b0;
        end else if (fire) begin
            sent_reg <= sent_next;
            recv_reg <= recv_next;
            busy_reg <= busy_next;
        end
    end

endmodule

>>> src/smbus_master_status_sequencer_unit.sv
// ---------------------------------------------------------------------------
// smbus_master_status_sequencer_unit
// SMBus master transfer sequencer: input register, status decode and
// state update, result register with back-pressure.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Word
//  s_      | in        | s_valid / s_ready   | func, slot, byte_value, status_code
//  m_      | out       | m_valid / m_ready   | tx_load .. rejected
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One word a cycle unless m_ready stalls; input and result are registered.
//  The result register and input register form a two-deep pipe; s_ready
//  drops only while both hold a word and m_ready is low.
//  cfg_ready is always high. Reset: counters 1, busy 0, lengths as reset.
//  Byte stores have no reset.
// ---------------------------------------------------------------------------
module smbus_master_status_sequencer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [smsseq_pkg::FUNC_W-1:0]    s_func,
    input  logic [smsseq_pkg::SLOT_W-1:0]    s_slot,
    input  logic [7:0]                       s_byte_value,
    input  logic [7:0]                       s_status_code,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_tx_load,
    output logic [7:0]                       m_tx_byte,
    output logic                             m_start_request,
    output logic                             m_stop_request,
    output logic                             m_ack_update,
    output logic                             m_ack_level,
    output logic                             m_engine_reset,
    output logic                             m_busy_res,
    output logic [7:0]                       m_read_byte,
    output logic                             m_rejected,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [smsseq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import smsseq_pkg::*;

    item_t   in_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res_reg, res_next;
    logic    m_valid_reg, m_valid_next;
    cfg_t    cfg_reg, cfg_next;
    logic    advance, fire, take;

    assign advance   = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign take      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SLAVE_ADDR: cfg_next.slave_address  = cfg_data;
                CFG_WRITE_LEN:  cfg_next.write_length   = cfg_data[CNT_W-1:0];
                CFG_READ_LEN:   cfg_next.read_length    = cfg_data[CNT_W-1:0];
                CFG_READ_DIR:   cfg_next.read_direction = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    smsseq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cfg_reg      <= '{slave_address: 8'd0, write_length: 5'd0,
                              read_length: 5'd1, read_direction: 1'b0};
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_reg <= '{func: s_func, slot: s_slot, byte_value: s_byte_value,
                        status_code: s_status_code};
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_tx_load       = res_reg.tx_load;
    assign m_tx_byte       = res_reg.tx_byte;
    assign m_start_request = res_reg.start_request;
    assign m_stop_request  = res_reg.stop_request;
    assign m_ack_update    = res_reg.ack_update;
    assign m_ack_level     = res_reg.ack_level;
    assign m_engine_reset  = res_reg.engine_reset;
    assign m_busy_res      = res_reg.busy_res;
    assign m_read_byte     = res_reg.read_byte;
    assign m_rejected      = res_reg.rejected;

endmodule

>>> src/smsseq_checker.sv
// ---------------------------------------------------------------------------
// smsseq_checker
// Port-level checks on the sequencer's result stream, bound to the top.
// ---------------------------------------------------------------------------
`include "smbus_master_status_sequencer_unit_assert.svh"

module smsseq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_tx_load,
    input logic [7:0] m_tx_byte,
    input logic       m_start_request,
    input logic       m_stop_request,
    input logic       m_engine_reset,
    input logic       m_busy_res,
    input logic       m_rejected
);
    `SMSSEQ_ASSERT_SAME(a_reject_keeps_busy, aclk, aresetn,
        m_valid && m_rejected, m_busy_res && !m_start_request)
    `SMSSEQ_ASSERT_SAME(a_engine_reset_frees, aclk, aresetn,
        m_valid && m_engine_reset, !m_busy_res && !m_tx_load)
    `SMSSEQ_ASSERT_SAME(a_stop_frees, aclk, aresetn,
        m_valid && m_stop_request, !m_busy_res && !m_tx_load)
    `SMSSEQ_ASSERT_NEXT(a_out_holds, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_tx_byte))

endmodule

bind smbus_master_status_sequencer_unit smsseq_checker u_smsseq_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_tx_load       (m_tx_load),
    .m_tx_byte       (m_tx_byte),
    .m_start_request (m_start_request),
    .m_stop_request  (m_stop_request),
    .m_engine_reset  (m_engine_reset),
    .m_busy_res      (m_busy_res),
    .m_rejected      (m_rejected)
);

>>> tb/sv/smbus_master_status_sequencer_unit_check.sv
// ---------------------------------------------------------------------------
// SMBus master sequencer checker
// Watches the input, result and register channels, predicts each result word
// from its own model of the sequencer and compares it field by field with
// the word the block returns.
// ---------------------------------------------------------------------------
module smbus_master_status_sequencer_unit_check (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [smsseq_pkg::FUNC_W-1:0]    s_func,
    input  logic [smsseq_pkg::SLOT_W-1:0]    s_slot,
    input  logic [7:0]                       s_byte_value,
    input  logic [7:0]                       s_status_code,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_tx_load,
    input  logic [7:0]                       m_tx_byte,
    input  logic                             m_start_request,
    input  logic                             m_stop_request,
    input  logic                             m_ack_update,
    input  logic                             m_ack_level,
    input  logic                             m_engine_reset,
    input  logic                             m_busy_res,
    input  logic [7:0]                       m_read_byte,
    input  logic                             m_rejected,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [smsseq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output int                               error_count,
    output int                               pending_words
);
    import smsseq_pkg::*;

    cfg_t             regs;
    logic [7:0]       tx_bytes [BUFFER_DEPTH];
    logic [7:0]       rx_bytes [BUFFER_DEPTH];
    logic [CNT_W-1:0] tx_index;
    logic [CNT_W-1:0] rx_index;
    logic             busy;
    result_t          due_words [$];

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
    endfunction

    function automatic logic [7:0] tx_fetch(input logic [CNT_W-1:0] c);
        if (c >= 1 && c <= BUFFER_DEPTH)
            return tx_bytes[c - 1];
        return 8'h00;
    endfunction

    function automatic void rx_keep(input logic [CNT_W-1:0] c, input logic [7:0] v);
        if (c >= 1 && c <= BUFFER_DEPTH)
            rx_bytes[c - 1] = v;
    endfunction

    function automatic result_t advance_sequencer(input item_t w);
        result_t r;
        r = '0;
        case (w.func)
            FN_LOAD: tx_bytes[w.slot] = w.byte_value;
            FN_START: begin
                if (busy) begin
                    r.rejected = 1'b1;
                end else begin
                    busy = 1'b1;
                    r.start_request = 1'b1;
                end
            end
            FN_STATUS: begin
                case (w.status_code)
                    ST_START, ST_RESTART: begin
                        r.tx_load = 1'b1;
                        r.tx_byte = (regs.slave_address & ADDR_MASK)
                                    | {7'd0, regs.read_direction};
                        tx_index = 5'd1;
                        rx_index = 5'd1;
                    end
                    ST_ADDR_W_ACK: begin
                        r.tx_load = 1'b1;
                        r.tx_byte = tx_fetch(tx_index);
                        tx_index = next_count(tx_index);
                    end
                    ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: r.start_request = 1'b1;
                    ST_DATA_W_ACK: begin
                        if (tx_index <= regs.write_length) begin
                            r.tx_load = 1'b1;
                            r.tx_byte = tx_fetch(tx_index);
                            tx_index = next_count(tx_index);
                        end else begin
                            r.stop_request = 1'b1;
                            busy = 1'b0;
                        end
                    end
                    ST_ADDR_R_ACK: begin
                        r.ack_update = 1'b1;
                        r.ack_level  = (rx_index != regs.read_length);
                    end
                    ST_DATA_R_ACK: begin
                        r.ack_update = 1'b1;
                        if (rx_index < regs.read_length) begin
                            rx_keep(rx_index, w.byte_value);
                            r.ack_level = 1'b1;
                            rx_index = next_count(rx_index);
                        end
                    end
                    ST_DATA_R_NACK: begin
                        rx_keep(rx_index, w.byte_value);
                        r.stop_request = 1'b1;
                        r.ack_update   = 1'b1;
                        r.ack_level    = 1'b1;
                        busy = 1'b0;
                    end
                    default: begin
                        // lost arbitration or unknown code
                        r.engine_reset = 1'b1;
                        r.ack_update   = 1'b1;
                        busy = 1'b0;
                    end
                endcase
            end
            FN_TIMEOUT: begin
                r.engine_reset = 1'b1;
                busy = 1'b0;
            end
            FN_READ: r.read_byte = rx_bytes[w.slot];
            default: ;
        endcase
        r.busy_res = busy;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        item_t   w;
        if (!aresetn) begin
            regs     = '{slave_address: 8'h00, write_length: 5'd0,
                         read_length: 5'd1, read_direction: 1'b0};
            tx_index = 5'd1;
            rx_index = 5'd1;
            busy     = 1'b0;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                tx_bytes[i] = 8'h00;
                rx_bytes[i] = 8'h00;
            end
            due_words.delete();
            error_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLAVE_ADDR: regs.slave_address  = cfg_data;
                    CFG_WRITE_LEN:  regs.write_length   = cfg_data[CNT_W-1:0];
                    CFG_READ_LEN:   regs.read_length    = cfg_data[CNT_W-1:0];
                    CFG_READ_DIR:   regs.read_direction = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                w = '{func: s_func, slot: s_slot, byte_value: s_byte_value,
                      status_code: s_status_code};
                due_words.push_back(advance_sequencer(w));
            end
            if (m_valid && m_ready) begin
                got = '{tx_load: m_tx_load, tx_byte: m_tx_byte,
                        start_request: m_start_request, stop_request: m_stop_request,
                        ack_update: m_ack_update, ack_level: m_ack_level,
                        engine_reset: m_engine_reset, busy_res: m_busy_res,
                        read_byte: m_read_byte, rejected: m_rejected};
                if (due_words.size() == 0) begin
                    flag_mismatch("unexpected word", 1, 0);
                end else begin
                    want = due_words.pop_front();
                    if (got.tx_load !== want.tx_load)
                        flag_mismatch("tx_load", got.tx_load, want.tx_load);
                    if (got.tx_byte !== want.tx_byte)
                        flag_mismatch("tx_byte", got.tx_byte, want.tx_byte);
                    if (got.start_request !== want.start_request)
                        flag_mismatch("start_request", got.start_request, want.start_request);
                    if (got.stop_request !== want.stop_request)
                        flag_mismatch("stop_request", got.stop_request, want.stop_request);
                    if (got.ack_update !== want.ack_update)
                        flag_mismatch("ack_update", got.ack_update, want.ack_update);
                    if (got.ack_level !== want.ack_level)
                        flag_mismatch("ack_level", got.ack_level, want.ack_level);
                    if (got.engine_reset !== want.engine_reset)
                        flag_mismatch("engine_reset", got.engine_reset, want.engine_reset);
                    if (got.busy_res !== want.busy_res)
                        flag_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.read_byte !== want.read_byte)
                        flag_mismatch("read_byte", got.read_byte, want.read_byte);
                    if (got.rejected !== want.rejected)
                        flag_mismatch("rejected", got.rejected, want.rejected);
                end
            end
        end
        pending_words = due_words.size();
    end

endmodule

>>> tb/sv/smbus_master_status_sequencer_unit_test.sv
// ---------------------------------------------------------------------------
// SMBus master sequencer testbench
// Fills both byte stores, runs a directed set of status codes and functions,
// then random well-formed write and read transfers mixed with loads,
// read-backs, bursts and noise under several register settings and idle
// patterns. The checker beside the block predicts and compares every word.
// ---------------------------------------------------------------------------
module smbus_master_status_sequencer_unit_test;
    import smsseq_pkg::*;

    localparam logic [7:0] ST_ARB_LOST = 8'h38;
    localparam logic [7:0] ST_NONE     = 8'h00;
    localparam logic [7:0] ST_BOGUS    = 8'hFF;
    localparam int         PHASE_WORDS = 182;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func        = '0;
    logic [SLOT_W-1:0]    s_slot        = '0;
    logic [7:0]           s_byte_value  = '0;
    logic [7:0]           s_status_code = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_tx_load;
    logic [7:0]           m_tx_byte;
    logic                 m_start_request;
    logic                 m_stop_request;
    logic                 m_ack_update;
    logic                 m_ack_level;
    logic                 m_engine_reset;
    logic                 m_busy_res;
    logic [7:0]           m_read_byte;
    logic                 m_rejected;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]           cfg_data      = '0;
    int                   error_count;
    int                   pending_words;

    int   send_idle_pct = 15;
    int   recv_idle_pct = 60;
    int   sent_items    = 0;
    int   cur_wlen      = 0;
    int   cur_rlen      = 1;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;

    smbus_master_status_sequencer_unit u_top (.*);

    smbus_master_status_sequencer_unit_check u_check (.*);

    always #2 aclk = ~aclk;

    // result side: random stalls, plus one long hold-off to fill the pipe
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= 80;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic item_t word_of(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] sl,
                                      input logic [7:0] bv, input logic [7:0] code);
        item_t w;
        w.func        = f;
        w.slot        = sl;
        w.byte_value  = bv;
        w.status_code = code;
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input item_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= w.func;
        s_slot        <= w.slot;
        s_byte_value  <= w.byte_value;
        s_status_code <= w.status_code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (w.func <= FN_READ)
            sent_items++;
    endtask

    task automatic plain(input logic [FUNC_W-1:0] f);
        issue(word_of(f, $urandom_range(15), $urandom_range(255), $urandom_range(255)));
    endtask

    task automatic status_event(input logic [7:0] code);
        issue(word_of(FN_STATUS, $urandom_range(15), $urandom_range(255), code));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_words != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] addr, input logic [CNT_W-1:0] wl,
                              input logic [CNT_W-1:0] rl, input logic dir);
        write_reg(CFG_SLAVE_ADDR, addr);
        write_reg(CFG_WRITE_LEN, {3'd0, wl});
        write_reg(CFG_READ_LEN, {3'd0, rl});
        write_reg(CFG_READ_DIR, {7'd0, dir});
        cfg_valid <= 1'b0;
        @(negedge aclk);
        cur_wlen = wl;
        cur_rlen = rl;
    endtask

    initial begin
        int pick;
        int end_pick;
        int target;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill every entry of both stores before anything reads them
        set_config($urandom_range(255), 16, 16, 1'b0);
        for (int i = 0; i < BUFFER_DEPTH; i++)
            issue(word_of(FN_LOAD, i[SLOT_W-1:0], $urandom_range(255), $urandom_range(255)));
        status_event(ST_START);
        repeat (BUFFER_DEPTH - 1) status_event(ST_DATA_R_ACK);
        status_event(ST_DATA_R_NACK);
        settle();

        // directed
        set_config(8'hFF, 0, 1, 1'b1);
        status_event(ST_ADDR_R_ACK);
        plain(FN_START);
        plain(FN_START);
        status_event(ST_START);
        status_event(ST_ADDR_W_ACK);
        status_event(ST_DATA_W_ACK);
        status_event(ST_ADDR_W_NACK);
        status_event(ST_DATA_W_NACK);
        status_event(ST_ADDR_R_NACK);
        status_event(ST_ADDR_R_ACK);
        issue(word_of(FN_STATUS, 4'd0, 8'h00, ST_DATA_R_ACK));
        issue(word_of(FN_STATUS, 4'd15, 8'hFF, ST_DATA_R_NACK));
        issue(word_of(FN_READ, 4'd0, 8'h00, ST_NONE));
        issue(word_of(FN_READ, 4'd15, 8'hFF, ST_BOGUS));
        status_event(ST_ARB_LOST);
        status_event(ST_BOGUS);
        status_event(ST_NONE);
        plain(FN_START);
        plain(FN_TIMEOUT);
        issue(word_of(FN_LOAD, 4'd0, 8'h00, ST_NONE));
        issue(word_of(FN_LOAD, 4'd15, 8'hFF, ST_BOGUS));
        for (int f = FN_READ + 1; f < 8; f++)
            plain(f[FUNC_W-1:0]);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            if (ph == 0)
                set_config(8'h00, 16, 16, 1'b0);
            else if (ph == 2)
                set_config(8'hFF, 0, 1, 1'b1);
            else
                set_config($urandom_range(255), $urandom_range(16), $urandom_range(1, 16),
                           $urandom_range(1));
            send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 60 : 0;
            recv_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 15 : 0;
            if (ph == 4)
                hold_req <= 1'b1;
            target = sent_items + PHASE_WORDS;
            while (sent_items < target) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    plain(FN_START);
                    status_event($urandom_range(1) ? ST_START : ST_RESTART);
                    if ($urandom_range(1)) begin
                        status_event(ST_ADDR_W_ACK);
                        repeat ($urandom_range(cur_wlen + 1)) status_event(ST_DATA_W_ACK);
                        end_pick = $urandom_range(9);
                        if (end_pick == 0)
                            status_event(ST_DATA_W_NACK);
                        else if (end_pick == 1)
                            status_event(ST_ADDR_W_NACK);
                        else if (end_pick == 2)
                            status_event(ST_ARB_LOST);
                        else
                            status_event(ST_DATA_W_ACK);
                    end else if ($urandom_range(9) == 0) begin
                        status_event(ST_ADDR_R_NACK);
                    end else begin
                        status_event(ST_ADDR_R_ACK);
                        repeat ($urandom_range(cur_rlen)) status_event(ST_DATA_R_ACK);
                        if ($urandom_range(9) == 0)
                            plain(FN_TIMEOUT);
                        else
                            status_event(ST_DATA_R_NACK);
                    end
                end else if (pick < 70) begin
                    plain(FN_LOAD);
                end else if (pick < 82) begin
                    plain(FN_READ);
                end else if (pick < 86) begin
                    // can run the send index past the store and into saturation
                    repeat ($urandom_range(12, 32)) status_event(ST_ADDR_W_ACK);
                end else if (pick < 90) begin
                    plain(FN_TIMEOUT);
                end else if (pick < 93) begin
                    plain(FN_START);
                end else begin
                    issue(word_of($urandom_range(7), $urandom_range(15), $urandom_range(255),
                                  $urandom_range(255)));
                end
            end
        end
        settle();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/smsseq_pkg.sv
src/smsseq_store.sv
src/smsseq_core.sv
src/smbus_master_status_sequencer_unit.sv
src/smsseq_checker.sv
tb/sv/smbus_master_status_sequencer_unit_check.sv
tb/sv/smbus_master_status_sequencer_unit_test.sv
